### src/ulbp_pkg.sv
// ----------------------------------------------------------------------------
// ulbp_pkg
// Shared types, constants and the LBP code-to-bin mapping for the uniform
// LBP(8,1) histogram block.
// ----------------------------------------------------------------------------
package ulbp_pkg;

    localparam int PX_W           = 8;
    localparam int NUM_NBR        = 8;
    localparam int NUM_BINS       = 58;
    localparam int TOP_BIN        = 57;
    localparam int BIN_W          = 6;
    localparam int BIN_CODE_W     = 7;
    localparam int OUT_W          = 16;
    localparam int COUNT_BITS_DEF = 16;

    // bin code returned for a non-uniform pattern
    localparam logic [BIN_CODE_W-1:0] BIN_NONUNIFORM = BIN_CODE_W'(NUM_BINS);
    localparam logic [BIN_CODE_W-1:0] BIN_ALL_ONES   = BIN_CODE_W'(TOP_BIN);
    localparam logic [BIN_CODE_W-1:0] BIN_ALL_ZERO   = '0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_UPD,
        S_RD,
        S_LOAD
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic accept;    // capture window, issue bin read, bump total
        logic upd;       // write incremented bin count
        logic rd_issue;  // readout: read bin at pointer
        logic load;      // readout: fill output register, clear bin
        logic finish;    // readout done: clear window total
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic block_end;
        logic ptr_last;
        logic out_free;
    } t_sts;

    function automatic logic [BIN_CODE_W-1:0] lbp_bin(input logic [NUM_NBR-1:0] code);
        logic [NUM_NBR-1:0] x;
        logic [3:0]         ones;
        logic [3:0]         trans;
        logic [2:0]         start;
        logic [2:0]         ones_m1;
        logic [BIN_CODE_W-1:0] res;
        x     = code ^ {code[NUM_NBR-2:0], code[NUM_NBR-1]};
        ones  = '0;
        trans = '0;
        start = '0;
        for (int i = 0; i < NUM_NBR; i++) begin
            ones  = ones + 4'(code[i]);
            trans = trans + 4'(x[i]);
            if (code[i] && !code[(i + NUM_NBR - 1) % NUM_NBR]) begin
                start = 3'(i);
            end
        end
        ones_m1 = ones[2:0] - 3'd1;
        if (code == '0) begin
            res = BIN_ALL_ZERO;
        end else if (code == '1) begin
            res = BIN_ALL_ONES;
        end else if (trans != 4'd2) begin
            res = BIN_NONUNIFORM;
        end else begin
            res = {1'b0, ones_m1, start} + BIN_CODE_W'(1);
        end
        return res;
    endfunction

endpackage

### src/ulbp_ram.sv
// ----------------------------------------------------------------------------
// ulbp_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ulbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 58
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/ulbp_ctrl.sv
// ----------------------------------------------------------------------------
// ulbp_ctrl
// Sequencer: per-window read-modify-write of one bin, then the 58-bin
// readout walk when the window closes a block.
// ----------------------------------------------------------------------------
module ulbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  ulbp_pkg::t_sts  i_sts,
    output logic            o_in_ready,
    output ulbp_pkg::t_cmd  o_cmd
);

    ulbp_pkg::t_state r_state;
    ulbp_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ulbp_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ulbp_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ulbp_pkg::S_UPD;
                end
            end
            ulbp_pkg::S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = i_sts.block_end ? ulbp_pkg::S_RD : ulbp_pkg::S_IDLE;
            end
            ulbp_pkg::S_RD: begin
                // only fetch once the output register will be empty
                if (i_sts.out_free) begin
                    o_cmd.rd_issue = 1'b1;
                    n_state        = ulbp_pkg::S_LOAD;
                end
            end
            ulbp_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.ptr_last) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ulbp_pkg::S_IDLE;
                end else begin
                    n_state = ulbp_pkg::S_RD;
                end
            end
            default: begin
                n_state = ulbp_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### src/ulbp_dp.sv
// ----------------------------------------------------------------------------
// ulbp_dp
// Datapath: LBP code and bin mapping, bin count RAM with valid bits,
// saturating counters, readout pointer and output register.
// ----------------------------------------------------------------------------
module ulbp_dp #(
    parameter int COUNT_BITS = ulbp_pkg::COUNT_BITS_DEF
) (
    input  logic                                                 i_clk,
    input  logic                                                 i_rst_n,
    input  ulbp_pkg::t_cmd                                       i_cmd,
    output ulbp_pkg::t_sts                                       o_sts,
    input  logic [ulbp_pkg::PX_W-1:0]                            i_center_px,
    input  logic [ulbp_pkg::NUM_NBR-1:0][ulbp_pkg::PX_W-1:0]     i_nbr_px,
    input  logic                                                 i_block_end,
    input  logic                                                 i_out_stall,
    output logic                                                 o_out_valid,
    output logic [ulbp_pkg::BIN_W-1:0]                           o_bin_index,
    output logic [ulbp_pkg::OUT_W-1:0]                           o_bin_count,
    output logic [ulbp_pkg::OUT_W-1:0]                           o_window_total,
    output logic                                                 o_last_bin
);

    localparam logic [ulbp_pkg::BIN_W-1:0] PTR_LAST = ulbp_pkg::BIN_W'(ulbp_pkg::TOP_BIN);

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    function automatic logic [ulbp_pkg::OUT_W-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [31:0] ext;
        ext = 32'(v);
        return (ext > 32'(16'hFFFF)) ? '1 : ext[ulbp_pkg::OUT_W-1:0];
    endfunction

    logic [ulbp_pkg::NUM_NBR-1:0]    code;
    logic [ulbp_pkg::BIN_CODE_W-1:0] bin_code;
    logic                            uni;
    logic [ulbp_pkg::BIN_W-1:0]      bin_addr;

    logic [ulbp_pkg::BIN_W-1:0]      r_bin;
    logic                            r_uni;
    logic                            r_end;
    logic                            r_hit;
    logic [ulbp_pkg::NUM_BINS-1:0]   r_valid;
    logic [COUNT_BITS-1:0]           r_wcnt;
    logic [ulbp_pkg::BIN_W-1:0]      r_ptr;
    logic                            r_out_valid;
    logic [ulbp_pkg::BIN_W-1:0]      r_out_idx;
    logic [ulbp_pkg::OUT_W-1:0]      r_out_cnt;
    logic [ulbp_pkg::OUT_W-1:0]      r_out_tot;
    logic                            r_out_last;

    logic                            ram_re;
    logic [ulbp_pkg::BIN_W-1:0]      ram_raddr;
    logic [COUNT_BITS-1:0]           ram_rdata;
    logic [COUNT_BITS-1:0]           cur_cnt;

    always_comb begin
        for (int i = 0; i < ulbp_pkg::NUM_NBR; i++) begin
            code[i] = i_nbr_px[i] > i_center_px;
        end
    end

    assign bin_code = ulbp_pkg::lbp_bin(code);
    assign uni      = bin_code != ulbp_pkg::BIN_NONUNIFORM;
    // non-uniform codes never write the store; park the address at 0
    assign bin_addr = uni ? bin_code[ulbp_pkg::BIN_W-1:0] : '0;

    assign ram_re    = i_cmd.accept | i_cmd.rd_issue;
    assign ram_raddr = i_cmd.rd_issue ? r_ptr : bin_addr;
    assign cur_cnt   = r_hit ? ram_rdata : '0;

    ulbp_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (ulbp_pkg::NUM_BINS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.upd & r_uni),
        .i_waddr (r_bin),
        .i_wdata (sat_inc(cur_cnt)),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_bin <= bin_addr;
            r_uni <= uni;
            r_end <= i_block_end;
        end
        // an entry never written since reset or readout reads as zero
        if (ram_re) begin
            r_hit <= r_valid[ram_raddr];
        end
        if (i_cmd.load) begin
            r_out_idx  <= r_ptr;
            r_out_cnt  <= sat_out(cur_cnt);
            r_out_tot  <= sat_out(r_wcnt);
            r_out_last <= r_ptr == PTR_LAST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_wcnt      <= '0;
            r_ptr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.upd && r_uni) begin
                r_valid[r_bin] <= 1'b1;
            end else if (i_cmd.load) begin
                r_valid[r_ptr] <= 1'b0;
            end
            if (i_cmd.accept) begin
                r_wcnt <= sat_inc(r_wcnt);
            end else if (i_cmd.finish) begin
                r_wcnt <= '0;
            end
            if (i_cmd.load) begin
                r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + ulbp_pkg::BIN_W'(1);
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.block_end = r_end;
    assign o_sts.ptr_last  = r_ptr == PTR_LAST;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_bin_index    = r_out_idx;
    assign o_bin_count    = r_out_cnt;
    assign o_window_total = r_out_tot;
    assign o_last_bin     = r_out_last;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_LAST)
        else $error("readout pointer out of range");

    a_load_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_out_valid)
        else $error("output register overwritten while holding a bin");

    a_finish_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load && (r_ptr == PTR_LAST) |=> (r_wcnt == '0) && (r_valid == '0))
        else $error("histogram not cleared after readout");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |=> (r_out_last == (r_out_idx == PTR_LAST)))
        else $error("last-bin flag out of step with bin index");

endmodule

### src/uniform_lbp_histogram.sv
// ----------------------------------------------------------------------------
// uniform_lbp_histogram
// Uniform LBP(8,1) histogram over 3x3 windows with 58-bin readout per block.
//
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-------------------------------------
//  window  | i_in_valid   | o_in_stall   | i_center_px, 8 neighbors, i_block_end
//  bin     | o_out_valid  | i_out_stall  | o_bin_index, o_bin_count,
//          |              |              | o_window_total, o_last_bin
//
// A window is a bin read from the count RAM, then write-back.
// A block-ending window adds a readout of 58 bins, one RAM read per bin.
// Reset clears the bin valid bits and window total at once; no clearing pass.
// Intake stalls during update and readout; output stalls hold the readout.
// ----------------------------------------------------------------------------
module uniform_lbp_histogram #(
    parameter int COUNT_BITS = ulbp_pkg::COUNT_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic [ulbp_pkg::PX_W-1:0]       i_center_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_up_left_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_up_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_up_right_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_right_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_down_right_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_down_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_down_left_px,
    input  logic [ulbp_pkg::PX_W-1:0]       i_left_px,
    input  logic                            i_block_end,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [ulbp_pkg::BIN_W-1:0]      o_bin_index,
    output logic [ulbp_pkg::OUT_W-1:0]      o_bin_count,
    output logic [ulbp_pkg::OUT_W-1:0]      o_window_total,
    output logic                            o_last_bin
);

    ulbp_pkg::t_cmd cmd;
    ulbp_pkg::t_sts sts;
    logic           in_ready;
    logic [ulbp_pkg::NUM_NBR-1:0][ulbp_pkg::PX_W-1:0] nbr_px;

    // index = LBP code bit position
    assign nbr_px = {i_left_px, i_down_left_px, i_down_px, i_down_right_px,
                     i_right_px, i_up_right_px, i_up_px, i_up_left_px};

    assign o_in_stall = !in_ready;

    ulbp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    ulbp_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_center_px    (i_center_px),
        .i_nbr_px       (nbr_px),
        .i_block_end    (i_block_end),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_bin_index    (o_bin_index),
        .o_bin_count    (o_bin_count),
        .o_window_total (o_window_total),
        .o_last_bin     (o_last_bin)
    );

endmodule
